// ===== design/mft_pkg.sv =====
// Package for the multi-turn motor feedback tracker.
// Shared constants, status codes, config indexes and the tracker request/response types.
// No dependencies.
package mft_pkg;

    localparam int ENCODER_COUNTS = 8192;
    localparam int ANGLE_W        = 13;
    localparam int TURN_W         = 16;
    localparam int FCNT_W         = 6;
    localparam int POS_W          = 30;
    localparam int RECIP_W        = 16;
    localparam int DATA_W         = 16;
    localparam int MIDX_W         = 3;
    localparam int ID_W           = 11;
    localparam int CFG_IDX_W      = 2;

    localparam logic [ID_W-1:0] BASE_ID = 11'h201;

    localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sd32767;
    localparam logic signed [TURN_W-1:0] TURN_MIN = -16'sd32767;

    localparam logic signed [31:0] POS_MAX = 32'sd536870911;
    localparam logic signed [31:0] POS_MIN = -32'sd536870912;

    typedef enum logic [1:0] {
        ST_UPDATED = 2'd0,
        ST_CAPTURE = 2'd1,
        ST_BAD_ID  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETTLE  = 2'd0,
        CFG_TYPES   = 2'd1,
        CFG_RECIP_A = 2'd2,
        CFG_RECIP_B = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic               upd;
        logic [MIDX_W-1:0]  index;
        logic [ANGLE_W-1:0] angle;
        logic [FCNT_W-1:0]  settle;
    } trk_req_t;

    typedef struct packed {
        status_t                  status;
        logic signed [POS_W-1:0]  pos;
    } trk_rsp_t;

endpackage

// ===== design/mft_track.sv =====
// Per-motor tracking table: offset capture, turn unwrapping and rotor position.
// Depends on mft_pkg. Response is combinational from the table; table updates on req.upd.
module mft_track #(
    parameter int NUM_MOTORS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mft_pkg::trk_req_t req,
    output mft_pkg::trk_rsp_t rsp
);

    localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam logic signed [mft_pkg::ANGLE_W:0] HALF =
        (mft_pkg::ANGLE_W+1)'(mft_pkg::ENCODER_COUNTS / 2);
    localparam logic signed [31:0] ENC_S = 32'(mft_pkg::ENCODER_COUNTS);

    logic [mft_pkg::FCNT_W-1:0]         fcnt_reg   [NUM_MOTORS];
    logic [mft_pkg::ANGLE_W-1:0]        prev_reg   [NUM_MOTORS];
    logic signed [mft_pkg::TURN_W-1:0]  turn_reg   [NUM_MOTORS];
    logic [mft_pkg::ANGLE_W-1:0]        offset_reg [NUM_MOTORS];

    logic [IDX_W-1:0]                   idx;
    logic [mft_pkg::FCNT_W-1:0]         fcnt;
    logic [mft_pkg::ANGLE_W-1:0]        prev;
    logic signed [mft_pkg::TURN_W-1:0]  turn;
    logic [mft_pkg::ANGLE_W-1:0]        offset;
    logic                               capture;
    logic signed [mft_pkg::ANGLE_W:0]   diff;
    logic [mft_pkg::FCNT_W-1:0]         fcnt_next;
    logic signed [mft_pkg::TURN_W-1:0]  turn_next;
    logic [mft_pkg::ANGLE_W-1:0]        offset_next;
    logic signed [31:0]                 pos_full;
    logic signed [31:0]                 pos_sat;

    assign idx    = req.index[IDX_W-1:0];
    assign fcnt   = fcnt_reg[idx];
    assign prev   = prev_reg[idx];
    assign turn   = turn_reg[idx];
    assign offset = offset_reg[idx];

    assign capture = (fcnt < req.settle);
    assign diff    = $signed({1'b0, req.angle}) - $signed({1'b0, prev});

    always_comb begin
        fcnt_next   = fcnt;
        turn_next   = turn;
        offset_next = offset;
        if (capture) begin
            fcnt_next   = fcnt + 1'b1;
            offset_next = req.angle;
        end else if (diff > HALF) begin
            if (turn != mft_pkg::TURN_MIN) begin
                turn_next = turn - 1'b1;
            end
        end else if (diff < -HALF) begin
            if (turn != mft_pkg::TURN_MAX) begin
                turn_next = turn + 1'b1;
            end
        end
    end

    always_comb begin
        pos_full = $signed(32'(turn_next)) * ENC_S
                 + $signed(32'(req.angle)) - $signed(32'(offset_next));
        if (pos_full > mft_pkg::POS_MAX) begin
            pos_sat = mft_pkg::POS_MAX;
        end else if (pos_full < mft_pkg::POS_MIN) begin
            pos_sat = mft_pkg::POS_MIN;
        end else begin
            pos_sat = pos_full;
        end
    end

    assign rsp.status = capture ? mft_pkg::ST_CAPTURE : mft_pkg::ST_UPDATED;
    assign rsp.pos    = pos_sat[mft_pkg::POS_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_MOTORS; i++) begin
                fcnt_reg[i]   <= '0;
                prev_reg[i]   <= '0;
                turn_reg[i]   <= '0;
                offset_reg[i] <= '0;
            end
        end else if (req.upd) begin
            fcnt_reg[idx]   <= fcnt_next;
            prev_reg[idx]   <= req.angle;
            turn_reg[idx]   <= turn_next;
            offset_reg[idx] <= offset_next;
        end
    end

endmodule

// ===== design/motor_feedback_multiturn_tracker.sv =====
// Multi-turn motor feedback tracker, top level. Stages from input accept to m_tvalid:
// input reg loads at the accept edge, then table stage, multiply stage, output reg.
// Throughput: one word per cycle unless m_tready stalls the output; the per-motor table
// read-modify-write sits in a single stage, so back-to-back words for the same motor
// need no forwarding. aresetn (sync, low) clears the motor table, all stage valids and
// loads the config reset values.
module motor_feedback_multiturn_tracker #(
    parameter int NUM_MOTORS = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    // config write port
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // {current_word[55:40], speed_word[39:24], angle_word[23:11], frame_id[10:0]}
    input  logic [55:0]  s_tdata,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], motor_index[4:2], rotor_angle[17:5], rotor_position[47:18],
    // axis_angle[95:48], axis_speed[127:96], rotor_speed[143:128], motor_current[159:144]
    output logic [159:0] m_tdata
);

    localparam int AW  = mft_pkg::ANGLE_W;
    localparam int DW  = mft_pkg::DATA_W;
    localparam int PW  = mft_pkg::POS_W;
    localparam int RW  = mft_pkg::RECIP_W;
    localparam int PRW = PW + RW + 1;   // pos * recip
    localparam int SPW = DW + RW + 1;   // speed * recip
    localparam int A3W = PRW + 9;       // times 360

    // config
    logic [mft_pkg::FCNT_W-1:0] settle_reg;
    logic [7:0]                 types_reg;
    logic [RW-1:0]              recip_a_reg;
    logic [RW-1:0]              recip_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg  <= 6'd50;
            types_reg   <= 8'd0;
            recip_a_reg <= 16'd3413;
            recip_b_reg <= 16'd1820;
        end else if (cfg_we) begin
            case (mft_pkg::cfg_idx_t'(cfg_index))
                mft_pkg::CFG_SETTLE:  settle_reg  <= cfg_wdata[mft_pkg::FCNT_W-1:0];
                mft_pkg::CFG_TYPES:   types_reg   <= cfg_wdata[7:0];
                mft_pkg::CFG_RECIP_A: recip_a_reg <= cfg_wdata;
                mft_pkg::CFG_RECIP_B: recip_b_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline flow control
    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic out_free, s2_free, s1_free, s0_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s0_free  = !s0_valid_reg || s1_free;
    assign s_tready = s0_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s0_free)  s0_valid_reg <= s_tvalid;
            if (s1_free)  s1_valid_reg <= s0_valid_reg;
            if (s2_free)  s2_valid_reg <= s1_valid_reg;
            if (out_free) m_valid_reg  <= s2_valid_reg;
        end
    end

    // stage 0: input register
    logic [mft_pkg::ID_W-1:0] s0_id_reg;
    logic [AW-1:0]            s0_angle_reg;
    logic [DW-1:0]            s0_speed_reg;
    logic [DW-1:0]            s0_current_reg;

    always_ff @(posedge aclk) begin
        if (s0_free && s_tvalid) begin
            s0_id_reg      <= s_tdata[10:0];
            s0_angle_reg   <= s_tdata[23:11];
            s0_speed_reg   <= s_tdata[39:24];
            s0_current_reg <= s_tdata[55:40];
        end
    end

    // stage 1: table update and rotor position
    logic [mft_pkg::ID_W-1:0]   id_off;
    logic                       id_ok;
    logic [mft_pkg::MIDX_W-1:0] midx;
    mft_pkg::trk_req_t          trk_req;
    mft_pkg::trk_rsp_t          trk_rsp;

    assign id_off = s0_id_reg - mft_pkg::BASE_ID;
    assign id_ok  = (s0_id_reg >= mft_pkg::BASE_ID) &&
                    (id_off < mft_pkg::ID_W'(NUM_MOTORS));
    assign midx   = id_off[mft_pkg::MIDX_W-1:0];

    assign trk_req.upd    = s0_valid_reg && s1_free && id_ok;
    assign trk_req.index  = midx;
    assign trk_req.angle  = s0_angle_reg;
    assign trk_req.settle = settle_reg;

    mft_track #(
        .NUM_MOTORS (NUM_MOTORS)
    ) u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (trk_req),
        .rsp     (trk_rsp)
    );

    mft_pkg::status_t           s1_status_reg;
    logic [mft_pkg::MIDX_W-1:0] s1_midx_reg;
    logic [AW-1:0]              s1_angle_reg;
    logic signed [PW-1:0]       s1_pos_reg;
    logic [RW-1:0]              s1_recip_reg;
    logic [DW-1:0]              s1_speed_reg;
    logic [DW-1:0]              s1_current_reg;

    always_ff @(posedge aclk) begin
        if (s1_free && s0_valid_reg) begin
            if (id_ok) begin
                s1_status_reg  <= trk_rsp.status;
                s1_midx_reg    <= midx;
                s1_angle_reg   <= s0_angle_reg;
                s1_pos_reg     <= trk_rsp.pos;
                s1_recip_reg   <= types_reg[midx] ? recip_b_reg : recip_a_reg;
                s1_speed_reg   <= s0_speed_reg;
                s1_current_reg <= s0_current_reg;
            end else begin
                // bad id: every field but status is zero
                s1_status_reg  <= mft_pkg::ST_BAD_ID;
                s1_midx_reg    <= '0;
                s1_angle_reg   <= '0;
                s1_pos_reg     <= '0;
                s1_recip_reg   <= '0;
                s1_speed_reg   <= '0;
                s1_current_reg <= '0;
            end
        end
    end

    // stage 2: multiplies
    mft_pkg::status_t           s2_status_reg;
    logic [mft_pkg::MIDX_W-1:0] s2_midx_reg;
    logic [AW-1:0]              s2_angle_reg;
    logic signed [PW-1:0]       s2_pos_reg;
    logic signed [PRW-1:0]      s2_prod_reg;
    logic signed [SPW-1:0]      s2_sprod_reg;
    logic [DW-1:0]              s2_speed_reg;
    logic [DW-1:0]              s2_current_reg;

    always_ff @(posedge aclk) begin
        if (s2_free && s1_valid_reg) begin
            s2_status_reg  <= s1_status_reg;
            s2_midx_reg    <= s1_midx_reg;
            s2_angle_reg   <= s1_angle_reg;
            s2_pos_reg     <= s1_pos_reg;
            s2_prod_reg    <= PRW'(s1_pos_reg * $signed({1'b0, s1_recip_reg}));
            s2_sprod_reg   <= SPW'($signed(s1_speed_reg) * $signed({1'b0, s1_recip_reg}));
            s2_speed_reg   <= s1_speed_reg;
            s2_current_reg <= s1_current_reg;
        end
    end

    // output stage: times 360 by shift-add, floor divide by the encoder count
    logic signed [A3W-1:0] prod_ext;
    logic signed [A3W-1:0] ang360;
    logic signed [A3W-1:0] ang_div;
    logic [159:0]          m_data_reg;

    assign prod_ext = A3W'(s2_prod_reg);
    assign ang360   = (prod_ext <<< 8) + (prod_ext <<< 6) + (prod_ext <<< 5) + (prod_ext <<< 3);
    assign ang_div  = ang360 >>> $clog2(mft_pkg::ENCODER_COUNTS);

    always_ff @(posedge aclk) begin
        if (out_free && s2_valid_reg) begin
            m_data_reg <= {s2_current_reg,
                           s2_speed_reg,
                           s2_sprod_reg[31:0],
                           48'(ang_div),
                           s2_pos_reg,
                           s2_angle_reg,
                           s2_midx_reg,
                           s2_status_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    a_bad_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg[1:0] == mft_pkg::ST_BAD_ID) |-> (m_data_reg[159:2] == '0))
        else $error("bad id result carries nonzero payload");

    a_capture_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg[1:0] == mft_pkg::ST_CAPTURE) |-> (m_data_reg[30:18] == '0))
        else $error("capture result position not a whole number of turns");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s0_valid_reg && s1_valid_reg && s2_valid_reg && m_valid_reg))
        else $error("input stalled while a pipeline stage is empty");

    a_upd_once: assert property (@(posedge aclk) disable iff (!aresetn)
        trk_req.upd |=> s1_valid_reg && (s1_status_reg != mft_pkg::ST_BAD_ID))
        else $error("table update without matching stage 1 word");

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the multi-turn motor feedback tracker: streams feedback words,
// predicts every result word with a local tracker model and compares it field by field.
// Depends on mft_pkg and motor_feedback_multiturn_tracker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_MOTORS = 8;
    localparam int IDLE_LIMIT = 1000;

    typedef struct packed {
        logic signed [mft_pkg::DATA_W-1:0] motor_current;
        logic signed [mft_pkg::DATA_W-1:0] rotor_speed;
        logic signed [31:0]                axis_speed;
        logic signed [47:0]                axis_angle;
        logic signed [mft_pkg::POS_W-1:0]  rotor_position;
        logic [mft_pkg::ANGLE_W-1:0]       rotor_angle;
        logic [mft_pkg::MIDX_W-1:0]        motor_index;
        mft_pkg::status_t                  status;
    } feedback_t;

    logic         aclk;
    logic         aresetn   = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [1:0]   cfg_index = mft_pkg::CFG_SETTLE;
    logic [15:0]  cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [55:0]  s_tdata   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [159:0] m_tdata;

    // tracker model: configuration and per-motor table
    logic [mft_pkg::FCNT_W-1:0]  settle_len = 6'd50;
    logic [7:0]                  gear_mask  = 8'h00;
    logic [mft_pkg::RECIP_W-1:0] recip_a    = 16'd3413;
    logic [mft_pkg::RECIP_W-1:0] recip_b    = 16'd1820;
    logic [mft_pkg::FCNT_W-1:0]  frame_cnt  [NUM_MOTORS] = '{default: '0};
    logic [mft_pkg::ANGLE_W-1:0] prev_angle [NUM_MOTORS] = '{default: '0};
    logic [mft_pkg::ANGLE_W-1:0] zero_offs  [NUM_MOTORS] = '{default: '0};
    int                          turns      [NUM_MOTORS] = '{default: 0};

    // last angle sent per motor, steers the random walk
    logic [mft_pkg::ANGLE_W-1:0] walk_angle [NUM_MOTORS] = '{default: '0};

    feedback_t   pending_feedback[$];
    int unsigned mismatch_count = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned idle_cycles    = 0;

    motor_feedback_multiturn_tracker #(.NUM_MOTORS(NUM_MOTORS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // frame id of motor m; m outside the motor range gives a bad id
    function automatic logic [mft_pkg::ID_W-1:0] motor_id(input int m);
        return mft_pkg::ID_W'(int'(mft_pkg::BASE_ID) + m);
    endfunction

    function automatic feedback_t predict_feedback(input logic [mft_pkg::ID_W-1:0] id,
                                                   input logic [mft_pkg::ANGLE_W-1:0] ang,
                                                   input logic signed [15:0] spd,
                                                   input logic signed [15:0] cur);
        feedback_t r;
        int        m;
        int        diff;
        longint    gain;
        longint    pos;
        longint    scaled;
        longint    quo;
        longint    spd_scaled;
        r = '0;
        r.status = mft_pkg::ST_BAD_ID;
        if (id < mft_pkg::BASE_ID || id >= mft_pkg::BASE_ID + NUM_MOTORS)
            return r;
        m = int'(id - mft_pkg::BASE_ID);
        if (frame_cnt[m] < settle_len) begin
            prev_angle[m] = ang;
            zero_offs[m]  = ang;
            frame_cnt[m]  = frame_cnt[m] + 1'b1;
            r.status      = mft_pkg::ST_CAPTURE;
        end else begin
            diff = int'(ang) - int'(prev_angle[m]);
            if (diff > mft_pkg::ENCODER_COUNTS / 2) begin
                if (turns[m] > mft_pkg::TURN_MIN)
                    turns[m]--;
            end else if (diff < -(mft_pkg::ENCODER_COUNTS / 2)) begin
                if (turns[m] < mft_pkg::TURN_MAX)
                    turns[m]++;
            end
            prev_angle[m] = ang;
            r.status      = mft_pkg::ST_UPDATED;
        end
        gain = gear_mask[m] ? longint'(recip_b) : longint'(recip_a);
        pos  = longint'(turns[m]) * mft_pkg::ENCODER_COUNTS + longint'(ang)
             - longint'(zero_offs[m]);
        if (pos > mft_pkg::POS_MAX)
            pos = mft_pkg::POS_MAX;
        if (pos < mft_pkg::POS_MIN)
            pos = mft_pkg::POS_MIN;
        // floor division, not truncation toward zero
        scaled = pos * 360 * gain;
        quo    = scaled / mft_pkg::ENCODER_COUNTS;
        if (scaled % mft_pkg::ENCODER_COUNTS != 0 && scaled < 0)
            quo--;
        spd_scaled       = longint'(spd) * gain;
        r.motor_index    = m[mft_pkg::MIDX_W-1:0];
        r.rotor_angle    = ang;
        r.rotor_position = pos[mft_pkg::POS_W-1:0];
        r.axis_angle     = quo[47:0];
        r.axis_speed     = spd_scaled[31:0];
        r.rotor_speed    = spd;
        r.motor_current  = cur;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // result word checker and receiver ready
    always @(posedge aclk) begin : result_check
        feedback_t got;
        feedback_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got = m_tdata;
            if (pending_feedback.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_feedback.pop_front();
                check_field("status",         64'(want.status),         64'(got.status));
                check_field("motor_index",    64'(want.motor_index),    64'(got.motor_index));
                check_field("rotor_angle",    64'(want.rotor_angle),    64'(got.rotor_angle));
                check_field("rotor_position", 64'(want.rotor_position),
                            64'(got.rotor_position));
                check_field("axis_angle",     64'(want.axis_angle),     64'(got.axis_angle));
                check_field("axis_speed",     64'(want.axis_speed),     64'(got.axis_speed));
                check_field("rotor_speed",    64'(want.rotor_speed),    64'(got.rotor_speed));
                check_field("motor_current",  64'(want.motor_current),
                            64'(got.motor_current));
            end
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_frame(input logic [mft_pkg::ID_W-1:0] id,
                              input logic [mft_pkg::ANGLE_W-1:0] ang,
                              input logic [15:0] spd, input logic [15:0] cur);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cur, spd, ang, id};
        do @(posedge aclk); while (s_tready !== 1'b1);
        pending_feedback.push_back(predict_feedback(id, ang, spd, cur));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_feedback.size() != 0);
    endtask

    task automatic apply_config(input logic [5:0] settle, input logic [7:0] mask,
                                input logic [15:0] ra, input logic [15:0] rb);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= mft_pkg::CFG_SETTLE;
        cfg_wdata <= {10'd0, settle};
        @(posedge aclk);
        cfg_index <= mft_pkg::CFG_TYPES;
        cfg_wdata <= {8'd0, mask};
        @(posedge aclk);
        cfg_index <= mft_pkg::CFG_RECIP_A;
        cfg_wdata <= ra;
        @(posedge aclk);
        cfg_index <= mft_pkg::CFG_RECIP_B;
        cfg_wdata <= rb;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        settle_len = settle;
        gear_mask  = mask;
        recip_a    = ra;
        recip_b    = rb;
    endtask

    task automatic test_bad_ids();
        apply_config(6'd2, 8'h0F, 16'd65535, 16'd1);
        send_frame(11'h000, 13'd8191, 16'h8000, 16'h7FFF);
        send_frame(motor_id(-1), 13'd1234, 16'h7FFF, 16'h8000);
        send_frame(motor_id(NUM_MOTORS), 13'd0, 16'hFFFF, 16'h0001);
        send_frame(11'h7FF, 13'd4096, 16'h0001, 16'hFFFF);
    endtask

    task automatic test_offset_capture();
        // motor 0 captures twice, then tracks; motor 1 goes negative with the smallest gain
        send_frame(motor_id(0), 13'd8191, 16'h7FFF, 16'h8000);
        send_frame(motor_id(0), 13'd0, 16'h8000, 16'h7FFF);
        send_frame(motor_id(0), 13'd5, 16'h7FFF, 16'h0000);
        send_frame(motor_id(3), 13'd1000, 16'h8000, 16'h0000);
        send_frame(motor_id(1), 13'd8000, 16'h0000, 16'h1234);
        send_frame(motor_id(1), 13'd7000, 16'hFFFF, 16'h8000);
        send_frame(motor_id(1), 13'd6000, 16'h8000, 16'h7FFF);
    endtask

    task automatic test_wrap_boundary();
        apply_config(6'd0, 8'hF0, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
        // a jump of exactly half a turn is no wrap, one count more is
        send_frame(motor_id(2), 13'd4096, 16'h0100, 16'h0010);
        send_frame(motor_id(2), 13'd8191, 16'h7FFF, 16'h0020);
        send_frame(motor_id(2), 13'd0, 16'h8000, 16'h0030);
        send_frame(motor_id(2), 13'd4097, 16'h0001, 16'h0040);
        send_frame(motor_id(4), 13'd8191, 16'hFFFF, 16'h0050);
        send_frame(motor_id(4), 13'd0, 16'h8000, 16'h7FFF);
    endtask

    task automatic test_settle_change();
        apply_config(6'd63, 8'hA5, 16'd3413, 16'd1820);
        send_frame(motor_id(5), 13'd300, 16'h0400, 16'h0001);
        send_frame(motor_id(5), 13'd400, 16'hFC00, 16'h0002);
        // lowering the settle length ends the capture early
        apply_config(6'd1, 8'hA5, 16'd3413, 16'd1820);
        send_frame(motor_id(5), 13'd500, 16'h0400, 16'h0003);
        // raising it above the frame count resumes it
        apply_config(6'd10, 8'hA5, 16'd3413, 16'd1820);
        send_frame(motor_id(5), 13'd600, 16'h0400, 16'h0004);
    endtask

    task automatic test_turn_tracking();
        apply_config(6'd0, 8'($urandom_range(0, 255)), 16'($urandom_range(1, 65535)),
                     16'($urandom_range(1, 65535)));
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // three words per turn: two steps of at most half a turn, one wrap; motor 6 climbs, motor 7 descends
        for (int k = 0; k < 3; k++) begin
            send_frame(motor_id(6), 13'd4096, 16'($urandom), 16'($urandom));
            send_frame(motor_id(6), 13'd8191, 16'($urandom), 16'($urandom));
            send_frame(motor_id(6), 13'd0, 16'($urandom), 16'($urandom));
        end
        for (int k = 0; k < 3; k++) begin
            send_frame(motor_id(7), 13'd8191, 16'($urandom), 16'($urandom));
            send_frame(motor_id(7), 13'd4095, 16'($urandom), 16'($urandom));
            send_frame(motor_id(7), 13'd0, 16'($urandom), 16'($urandom));
        end
        walk_angle[6] = 13'd0;
        walk_angle[7] = 13'd0;
    endtask

    task automatic send_random_frame();
        int                          m;
        int                          pick;
        int                          step;
        logic [mft_pkg::ID_W-1:0]    id;
        logic [mft_pkg::ANGLE_W-1:0] ang;
        logic [15:0]                 spd;
        logic [15:0]                 cur;
        m  = $urandom_range(0, NUM_MOTORS - 1);
        id = motor_id(m);
        if ($urandom_range(99) < 8)
            id = 11'($urandom_range(0, 2047));
        pick = $urandom_range(99);
        if (pick < 60) begin
            step = $urandom_range(0, 2400);
            ang  = 13'(int'(walk_angle[m]) + step - 1200);
        end else if (pick < 80) begin
            // around the wrap threshold, either direction
            step = $urandom_range(4094, 4098);
            ang  = $urandom_range(1) ? 13'(int'(walk_angle[m]) + step)
                                     : 13'(int'(walk_angle[m]) - step);
        end else begin
            ang = 13'($urandom_range(0, 8191));
        end
        walk_angle[m] = ang;
        spd = 16'($urandom_range(0, 65535));
        cur = 16'($urandom_range(0, 65535));
        if ($urandom_range(99) < 10)
            spd = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        if ($urandom_range(99) < 10)
            cur = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        send_frame(id, ang, spd, cur);
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    apply_config(6'd4, 8'h00, 16'd3413, 16'd1820);
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    apply_config(6'd0, 8'hFF, 16'd1, 16'd65535);
                    src_idle_pct   = 63;
                    sink_stall_pct = 0;
                end
                2: begin
                    apply_config(6'd63, 8'($urandom_range(0, 255)),
                                 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
                    src_idle_pct   = 0;
                    sink_stall_pct = 63;
                end
                default: begin
                    apply_config(6'($urandom_range(0, 8)), 8'($urandom_range(0, 255)),
                                 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
                    src_idle_pct   = 18;
                    sink_stall_pct = 18;
                end
            endcase
            for (int n = 0; n < 104; n++) begin
                if (n == 52)
                    wait_drained();
                send_random_frame();
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_bad_ids();
        test_offset_capture();
        test_wrap_boundary();
        test_settle_change();
        test_turn_tracking();
        test_random_traffic();
        sink_stall_pct = 0;
        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
